>>> rtl/vsag_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsag_pkg
// Shared types, register indexes and helpers of the scanline address generator.
// ----------------------------------------------------------------------------
package vsag_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int REPEAT_BITS    = 6;

    // address bits taken over by the row counter in interleaved modes
    localparam int ADDR_BIT_LO = 14;
    localparam int ADDR_BIT_HI = 15;

    // shift control value that selects the cga repeat rule
    localparam logic [1:0] SHIFT_MODE_CGA = 2'd1;

    // register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_START_ADDRESS  = 3'd0,
        CFG_ROW_OFFSET     = 3'd1,
        CFG_COMPARE_LINE   = 3'd2,
        CFG_MAX_SCAN_LINE  = 3'd3,
        CFG_DOUBLE_SCAN_ON = 3'd4,
        CFG_SHIFT_MODE     = 3'd5,
        CFG_CRTC_MODE      = 3'd6,
        CFG_FRAME_LINES    = 3'd7
    } cfg_index_t;

    // register file contents
    typedef struct packed {
        logic [15:0] start_address;
        logic [15:0] row_offset;
        logic [10:0] compare_line;
        logic [4:0]  max_scan_line;
        logic        double_scan_on;
        logic [1:0]  shift_mode;
        logic [7:0]  crtc_mode;
        logic [11:0] frame_lines;
    } cfg_t;

    // reset values
    localparam logic [15:0] RST_START_ADDRESS = 16'd0;
    localparam logic [15:0] RST_ROW_OFFSET    = 16'd0;
    localparam logic [10:0] RST_COMPARE_LINE  = 11'd2047;
    localparam logic [4:0]  RST_MAX_SCAN_LINE = 5'd0;
    localparam logic        RST_DOUBLE_SCAN   = 1'b0;
    localparam logic [1:0]  RST_SHIFT_MODE    = 2'd0;
    localparam logic [7:0]  RST_CRTC_MODE     = 8'd3;
    localparam logic [11:0] RST_FRAME_LINES   = 12'd480;

    // scanlines per row minus one
    function automatic logic [REPEAT_BITS-1:0] repeat_count(input cfg_t cfg);
        logic [REPEAT_BITS:0] rows;
        logic [REPEAT_BITS:0] scaled;
        begin
            rows   = {2'b00, cfg.max_scan_line} + 7'd1;
            scaled = cfg.double_scan_on ? (rows << 1) : rows;
            scaled = scaled - 7'd1;
            if (cfg.shift_mode != SHIFT_MODE_CGA)
            begin
                repeat_count = scaled[REPEAT_BITS-1:0];
            end
            else
            begin
                repeat_count = {{(REPEAT_BITS-1){1'b0}}, cfg.double_scan_on};
            end
        end
    endfunction

endpackage

>>> rtl/vsag_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsag_cfg_regs
// Register file written through the configuration channel.
// ----------------------------------------------------------------------------
module vsag_cfg_regs
    import vsag_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // decode one register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_START_ADDRESS:  cfg_next.start_address  = cfg_data;
                CFG_ROW_OFFSET:     cfg_next.row_offset     = cfg_data;
                CFG_COMPARE_LINE:   cfg_next.compare_line   = cfg_data[10:0];
                CFG_MAX_SCAN_LINE:  cfg_next.max_scan_line  = cfg_data[4:0];
                CFG_DOUBLE_SCAN_ON: cfg_next.double_scan_on = cfg_data[0];
                CFG_SHIFT_MODE:     cfg_next.shift_mode     = cfg_data[1:0];
                CFG_CRTC_MODE:      cfg_next.crtc_mode      = cfg_data[7:0];
                CFG_FRAME_LINES:    cfg_next.frame_lines    = cfg_data[11:0];
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_address  <= RST_START_ADDRESS;
            cfg_reg.row_offset     <= RST_ROW_OFFSET;
            cfg_reg.compare_line   <= RST_COMPARE_LINE;
            cfg_reg.max_scan_line  <= RST_MAX_SCAN_LINE;
            cfg_reg.double_scan_on <= RST_DOUBLE_SCAN;
            cfg_reg.shift_mode     <= RST_SHIFT_MODE;
            cfg_reg.crtc_mode      <= RST_CRTC_MODE;
            cfg_reg.frame_lines    <= RST_FRAME_LINES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/vsag_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsag_core
// Scan state (line base, row counter, repeat count, line index) and the
// address of the current scanline.
// ----------------------------------------------------------------------------
module vsag_core
    import vsag_pkg::*;
#(
    parameter int ADDR_BITS = 22,
    parameter int LINE_BITS = 11
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 step,
    input  logic                 frame_start,
    output logic [ADDR_BITS-1:0] line_address,
    output logic [LINE_BITS-1:0] line_number,
    output logic                 frame_done
);

    localparam int LEN_BITS = (LINE_BITS + 1 > 12) ? LINE_BITS + 1 : 12;
    localparam int CMP_BITS = (LINE_BITS > 11) ? LINE_BITS : 11;

    logic [ADDR_BITS-1:0]   line_base_reg,    line_base_next;
    logic [LINE_BITS-1:0]   row_counter_reg,  row_counter_next;
    logic [REPEAT_BITS-1:0] repeat_left_reg,  repeat_left_next;
    logic [LINE_BITS-1:0]   display_line_reg, display_line_next;

    logic                   frame_begin;
    logic [ADDR_BITS-1:0]   base_cur;
    logic [LINE_BITS-1:0]   row_cur;
    logic [REPEAT_BITS-1:0] repeat_cur;
    logic [LINE_BITS-1:0]   line_cur;
    logic [ADDR_BITS-1:0]   addr;
    logic [1:0]             row_mask;
    logic                   last;
    logic                   compare_hit;

    // frame start reloads the scan state
    always_comb
    begin
        frame_begin = frame_start || (display_line_reg == '0);
        base_cur    = frame_begin ? ADDR_BITS'({cfg.start_address, 2'b00}) : line_base_reg;
        row_cur     = frame_begin ? '0 : row_counter_reg;
        repeat_cur  = frame_begin ? repeat_count(cfg) : repeat_left_reg;
        line_cur    = frame_begin ? '0 : display_line_reg;
    end

    // row counter interleave into address bits 14 and 15
    always_comb
    begin
        addr = base_cur;
        if (!cfg.crtc_mode[0])
        begin
            if (cfg.crtc_mode[6])
            begin
                addr[ADDR_BIT_HI] = row_cur[0];
            end
            else
            begin
                addr[ADDR_BIT_LO] = row_cur[0];
            end
        end
        if (!cfg.crtc_mode[1])
        begin
            addr[ADDR_BIT_HI] = row_cur[1];
        end
    end

    // last line and line compare
    always_comb
    begin
        last = (LEN_BITS'(line_cur) + LEN_BITS'(1) >= LEN_BITS'(cfg.frame_lines))
            || (line_cur == {LINE_BITS{1'b1}});
        compare_hit = (CMP_BITS'(line_cur) == CMP_BITS'(cfg.compare_line));
    end

    assign line_address = addr;
    assign line_number  = line_cur;
    assign frame_done   = last;

    // next scan state
    always_comb
    begin
        row_mask         = ~cfg.crtc_mode[1:0];
        line_base_next   = base_cur;
        row_counter_next = row_cur;
        if (repeat_cur == '0)
        begin
            if ((row_cur[1:0] & row_mask) == row_mask)
            begin
                line_base_next = base_cur + ADDR_BITS'(cfg.row_offset);
            end
            row_counter_next = row_cur + LINE_BITS'(1);
            repeat_left_next = repeat_count(cfg);
        end
        else
        begin
            repeat_left_next = repeat_cur - REPEAT_BITS'(1);
        end
        if (compare_hit)
        begin
            line_base_next = '0;
        end
        display_line_next = last ? '0 : line_cur + LINE_BITS'(1);
    end

    // scan state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_base_reg    <= ADDR_BITS'({RST_START_ADDRESS, 2'b00});
            row_counter_reg  <= '0;
            repeat_left_reg  <= '0;
            display_line_reg <= '0;
        end
        else if (step)
        begin
            line_base_reg    <= line_base_next;
            row_counter_reg  <= row_counter_next;
            repeat_left_reg  <= repeat_left_next;
            display_line_reg <= display_line_next;
        end
    end

endmodule

>>> rtl/vsag_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsag_out_stage
// Result register between the address logic and the output stream.
// ----------------------------------------------------------------------------
module vsag_out_stage #(
    parameter int DATA_BITS = 40
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [DATA_BITS-1:0] in_data,
    input  logic                 in_last,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_BITS-1:0] m_tdata,
    output logic                 m_tlast
);

    logic                 valid_reg;
    logic [DATA_BITS-1:0] data_reg;
    logic                 last_reg;

    // room when empty or when the held item leaves this cycle
    assign in_ready = !valid_reg || m_tready;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
            last_reg <= in_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

>>> rtl/vga_scanline_address_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vga_scanline_address_generator_top
// One video memory byte address per displayed scanline.
// ----------------------------------------------------------------------------
// Each input item stands for one scanline; bit 0 of s_tdata forces a new
// frame. The result carries the line's byte address, its line number within
// the frame, and tlast on the frame's last line. An item is taken every clock
// cycle and its result appears on the output in the next cycle; the single
// output register is the only buffering, so the input stalls only while that
// register holds a result the sink has not taken. Configuration writes are
// always accepted and must happen while no item is in flight.
module vga_scanline_address_generator_top
    import vsag_pkg::*;
#(
    parameter int ADDR_BITS = 22,
    parameter int LINE_BITS = 11
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [0] frame_start
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [ADDR_BITS-1:0] line_address, then line_number, zero padded
    output logic [((ADDR_BITS+LINE_BITS+7)/8)*8-1:0] m_tdata,
    output logic                      m_tlast,   // frame_done
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int DATA_BITS = ((ADDR_BITS + LINE_BITS + 7) / 8) * 8;

    cfg_t                 cfg;
    logic                 step;
    logic [ADDR_BITS-1:0] line_address;
    logic [LINE_BITS-1:0] line_number;
    logic                 frame_done;
    logic [DATA_BITS-1:0] result_data;

    // configuration registers
    vsag_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign step = s_tvalid && s_tready;

    // scan state and address logic
    vsag_core #(
        .ADDR_BITS (ADDR_BITS),
        .LINE_BITS (LINE_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .step         (step),
        .frame_start  (s_tdata[0]),
        .line_address (line_address),
        .line_number  (line_number),
        .frame_done   (frame_done)
    );

    // pack result fields
    assign result_data = DATA_BITS'({line_number, line_address});

    // result register
    vsag_out_stage #(
        .DATA_BITS (DATA_BITS)
    ) u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (result_data),
        .in_last  (frame_done),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> rtl/vsag_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsag_checker
// Port-level checks of the scanline address generator, bound to the top.
// ----------------------------------------------------------------------------
module vsag_checker
    import vsag_pkg::*;
#(
    parameter int ADDR_BITS = 22,
    parameter int LINE_BITS = 11
)
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic [7:0]                s_tdata,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [((ADDR_BITS+LINE_BITS+7)/8)*8-1:0] m_tdata,
    input logic                      m_tlast,
    input logic                      cfg_valid,
    input logic                      cfg_ready,
    input logic [CFG_INDEX_BITS-1:0] cfg_index,
    input logic [CFG_DATA_BITS-1:0]  cfg_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // every accepted item shows a result on the next cycle
    a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted item gave no result");

    // input is never blocked while the output can move
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled with room in result register");

    // register writes are never refused
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("register write refused");

    // offered items and register writes carry known bits
    a_known_inputs: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid || cfg_valid |-> !$isunknown({s_tdata, cfg_index, cfg_data}))
        else $error("unknown bits on an offered item or register write");

endmodule

bind vga_scanline_address_generator_top vsag_checker #(
    .ADDR_BITS (ADDR_BITS),
    .LINE_BITS (LINE_BITS)
) u_vsag_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);

>>> tb/vga_scanline_address_generator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vga_scanline_address_generator_top_tb
// Self-checking bench for the scanline address generator.
// ----------------------------------------------------------------------------
// Scanline items go in on the slave stream and their line addresses come back
// on the master stream. A model of the line counter, row counter and base
// address runs beside the block and queues the result of every accepted item.
// Each returned item is checked field by field against the oldest entry.
// Registers are rewritten only once the stream has drained. The run goes
// through directed corner settings, one long frame, and random
// settings under four idling patterns.
// ----------------------------------------------------------------------------
module vga_scanline_address_generator_top_tb;
    import vsag_pkg::*;

    localparam int ADDR_BITS   = 22;
    localparam int LINE_BITS   = 11;
    localparam int TDATA_W     = ((ADDR_BITS + LINE_BITS + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RAND_PHASES = 24;
    localparam int PHASE_LINES = 55;

    typedef struct packed {
        logic [ADDR_BITS-1:0] line_address;
        logic [LINE_BITS-1:0] line_number;
        logic                 frame_done;
    } scan_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [7:0]                s_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [TDATA_W-1:0]        m_tdata;
    logic                      m_tlast;
    logic                      cfg_valid;
    logic                      cfg_ready;
    cfg_index_t                cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    // register mirror and scan state of the model
    cfg_t                      regs;
    logic [ADDR_BITS-1:0]      base_addr;
    logic [LINE_BITS-1:0]      row_cnt;
    logic [5:0]                repeats_left;
    logic [LINE_BITS-1:0]      disp_line;

    scan_result_t              expected_lines[$];
    scan_result_t              want;
    int                        error_count;
    int                        lines_sent;
    int                        frames_seen;
    int                        compare_hits;
    int                        reg_writes;
    int                        cycle_count;
    int                        send_idle_pct;
    int                        recv_stall_pct;

    vga_scanline_address_generator_top #(
        .ADDR_BITS (ADDR_BITS),
        .LINE_BITS (LINE_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run time guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // lines per character row minus one
    function automatic logic [5:0] row_repeat();
        int n;
        if (regs.shift_mode == SHIFT_MODE_CGA)
        begin
            return {5'b0, regs.double_scan_on};
        end
        n = (int'(regs.max_scan_line) + 1) << regs.double_scan_on;
        return 6'(n - 1);
    endfunction

    function automatic void restart_frame();
        base_addr    = {4'b0, regs.start_address, 2'b00};
        row_cnt      = '0;
        repeats_left = row_repeat();
        disp_line    = '0;
    endfunction

    // address, line number and frame end of one scanline; advances the model
    function automatic scan_result_t next_line(input logic frame_start);
        scan_result_t         res;
        logic [ADDR_BITS-1:0] addr;
        logic [1:0]           row_mask;
        logic                 last;
        if (frame_start || disp_line == '0)
        begin
            restart_frame();
        end
        addr = base_addr;
        // cga / hercules interleave
        if (!regs.crtc_mode[0])
        begin
            if (regs.crtc_mode[6])
            begin
                addr[ADDR_BIT_HI] = row_cnt[0];
            end
            else
            begin
                addr[ADDR_BIT_LO] = row_cnt[0];
            end
        end
        if (!regs.crtc_mode[1])
        begin
            addr[ADDR_BIT_HI] = row_cnt[1];
        end
        last = (int'(disp_line) + 1 >= int'(regs.frame_lines)) || (&disp_line);
        res.line_address = addr;
        res.line_number  = disp_line;
        res.frame_done   = last;
        // row end: step the base when the interleaved row bits are all set
        if (repeats_left == '0)
        begin
            row_mask = ~regs.crtc_mode[1:0];
            if ((row_cnt[1:0] & row_mask) == row_mask)
            begin
                base_addr = base_addr + ADDR_BITS'(regs.row_offset);
            end
            row_cnt      = row_cnt + LINE_BITS'(1);
            repeats_left = row_repeat();
        end
        else
        begin
            repeats_left = repeats_left - 6'd1;
        end
        // line compare restarts the base at zero
        if (disp_line == regs.compare_line)
        begin
            base_addr = '0;
            compare_hits++;
        end
        disp_line = last ? '0 : disp_line + LINE_BITS'(1);
        return res;
    endfunction

    // result checker, model update and register mirror
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_lines.size() == 0)
                begin
                    $error("unexpected item: line_address %0h line_number %0d",
                           m_tdata[ADDR_BITS-1:0], m_tdata[ADDR_BITS +: LINE_BITS]);
                    error_count++;
                end
                else
                begin
                    want = expected_lines.pop_front();
                    if (m_tdata[ADDR_BITS-1:0] !== want.line_address)
                    begin
                        $error("line_address mismatch: expected %0h, got %0h",
                               want.line_address, m_tdata[ADDR_BITS-1:0]);
                        error_count++;
                    end
                    if (m_tdata[ADDR_BITS +: LINE_BITS] !== want.line_number)
                    begin
                        $error("line_number mismatch: expected %0d, got %0d",
                               want.line_number, m_tdata[ADDR_BITS +: LINE_BITS]);
                        error_count++;
                    end
                    if (m_tlast !== want.frame_done)
                    begin
                        $error("frame_done mismatch: expected %0b, got %0b",
                               want.frame_done, m_tlast);
                        error_count++;
                    end
                    if (want.frame_done)
                    begin
                        frames_seen++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_lines.push_back(next_line(s_tdata[0]));
                lines_sent++;
            end
            if (cfg_valid && cfg_ready)
            begin
                reg_writes++;
                case (cfg_index)
                    CFG_START_ADDRESS:  regs.start_address  = cfg_data;
                    CFG_ROW_OFFSET:     regs.row_offset     = cfg_data;
                    CFG_COMPARE_LINE:   regs.compare_line   = cfg_data[10:0];
                    CFG_MAX_SCAN_LINE:  regs.max_scan_line  = cfg_data[4:0];
                    CFG_DOUBLE_SCAN_ON: regs.double_scan_on = cfg_data[0];
                    CFG_SHIFT_MODE:     regs.shift_mode     = cfg_data[1:0];
                    CFG_CRTC_MODE:      regs.crtc_mode      = cfg_data[7:0];
                    CFG_FRAME_LINES:    regs.frame_lines    = cfg_data[11:0];
                    default:            ;
                endcase
            end
        end
    end

    // sink side back-pressure
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    // one scanline item, with random idle cycles ahead of it
    task automatic send_line(input logic frame_start);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, frame_start};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
    endtask

    // stop sending and wait until every queued result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_lines.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
    endtask

    // write all eight registers; unused upper data bits carry noise
    task automatic apply_settings(input cfg_t c);
        write_reg(CFG_START_ADDRESS,  c.start_address);
        write_reg(CFG_ROW_OFFSET,     c.row_offset);
        write_reg(CFG_COMPARE_LINE,   {5'($urandom), c.compare_line});
        write_reg(CFG_MAX_SCAN_LINE,  {11'($urandom), c.max_scan_line});
        write_reg(CFG_DOUBLE_SCAN_ON, {15'($urandom), c.double_scan_on});
        write_reg(CFG_SHIFT_MODE,     {14'($urandom), c.shift_mode});
        write_reg(CFG_CRTC_MODE,      {8'($urandom), c.crtc_mode});
        write_reg(CFG_FRAME_LINES,    {4'($urandom), c.frame_lines});
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic cfg_t random_settings();
        cfg_t c;
        int   r;
        r = $urandom_range(0, 99);
        if (r < 5)
            c.frame_lines = 12'd0;
        else if (r < 10)
            c.frame_lines = 12'd1;
        else if (r < 78)
            c.frame_lines = 12'($urandom_range(2, 40));
        else if (r < 94)
            c.frame_lines = 12'($urandom_range(41, 300));
        else
            c.frame_lines = 12'($urandom);
        if ($urandom_range(0, 99) < 65)
            c.compare_line = 11'($urandom_range(0, int'(c.frame_lines) + 1));
        else
            c.compare_line = 11'($urandom);
        r = $urandom_range(0, 99);
        if (r < 50)
            c.max_scan_line = 5'($urandom_range(0, 3));
        else if (r < 65)
            c.max_scan_line = 5'd31;
        else
            c.max_scan_line = 5'($urandom);
        r = $urandom_range(0, 9);
        if (r == 0)
            c.row_offset = 16'hffff;
        else if (r == 1)
            c.row_offset = 16'h0000;
        else
            c.row_offset = 16'($urandom);
        c.start_address  = 16'($urandom);
        c.double_scan_on = 1'($urandom);
        c.shift_mode     = 2'($urandom);
        c.crtc_mode      = 8'($urandom);
        return c;
    endfunction

    // reset values, interleave on both bits, compare line, one-line frames,
    // frame restart in the middle of a frame
    task automatic test_directed();
        cfg_t c;
        set_idling(0, 0);
        send_line(1'b1);
        send_line(1'b0);
        send_line(1'b0);
        wait_drained();

        // largest start and offset, both interleave bits, compare mid-frame
        c.start_address  = 16'hffff;
        c.row_offset     = 16'hffff;
        c.compare_line   = 11'd3;
        c.max_scan_line  = 5'd1;
        c.double_scan_on = 1'b0;
        c.shift_mode     = 2'd0;
        c.crtc_mode      = 8'h00;
        c.frame_lines    = 12'd8;
        apply_settings(c);
        send_line(1'b1);
        repeat (8) send_line(1'b0);
        wait_drained();

        // cga repeat rule, bit 15 select, zero-length frames, compare at line 0
        c.start_address  = 16'h1234;
        c.row_offset     = 16'h0050;
        c.compare_line   = 11'd0;
        c.max_scan_line  = 5'd31;
        c.double_scan_on = 1'b1;
        c.shift_mode     = SHIFT_MODE_CGA;
        c.crtc_mode      = 8'h42;
        c.frame_lines    = 12'd0;
        apply_settings(c);
        repeat (4) send_line(1'b0);
        wait_drained();

        // deepest row repeat, frame start forced mid-frame
        c.start_address  = 16'h0000;
        c.row_offset     = 16'h0001;
        c.compare_line   = 11'd2047;
        c.max_scan_line  = 5'd31;
        c.double_scan_on = 1'b1;
        c.shift_mode     = 2'd3;
        c.crtc_mode      = 8'hc1;
        c.frame_lines    = 12'd6;
        apply_settings(c);
        send_line(1'b0);
        send_line(1'b0);
        send_line(1'b1);
        send_line(1'b0);
        send_line(1'b1);
        send_line(1'b0);
        wait_drained();
    endtask

    // long frame that outlasts this test: base address wraps,
    // compare far into the frame
    task automatic test_long_frame();
        cfg_t c;
        set_idling(0, 0);
        c.start_address  = 16'hffff;
        c.row_offset     = 16'hffff;
        c.compare_line   = 11'd400;
        c.max_scan_line  = 5'd0;
        c.double_scan_on = 1'b0;
        c.shift_mode     = 2'd0;
        c.crtc_mode      = 8'h03;
        c.frame_lines    = 12'hfff;
        apply_settings(c);
        send_line(1'b1);
        repeat (599) send_line(1'b0);
        wait_drained();
    endtask

    // random settings and frames under each idling pattern
    task automatic test_random();
        cfg_t c;
        int   p;
        int   n;
        for (p = 0; p < RAND_PHASES; p++)
        begin
            case (p % 4)
                0: set_idling(0, 0);
                1: set_idling(73, 0);
                2: set_idling(0, 73);
                default: set_idling(21, 21);
            endcase
            c = random_settings();
            apply_settings(c);
            send_line(1'($urandom_range(0, 1)));
            for (n = 1; n < PHASE_LINES; n++)
            begin
                // sender holds off until the stream is empty
                if (p % 3 == 1 && n == PHASE_LINES / 2)
                begin
                    wait_drained();
                end
                send_line($urandom_range(0, 99) < 3);
            end
            wait_drained();
        end
    endtask

    initial
    begin
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        m_tready     <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= CFG_START_ADDRESS;
        cfg_data     <= '0;
        rst_n        <= 1'b0;
        error_count  = 0;
        lines_sent   = 0;
        frames_seen  = 0;
        compare_hits = 0;
        reg_writes   = 0;
        cycle_count  = 0;
        set_idling(0, 0);

        // model reset state
        regs.start_address  = RST_START_ADDRESS;
        regs.row_offset     = RST_ROW_OFFSET;
        regs.compare_line   = RST_COMPARE_LINE;
        regs.max_scan_line  = RST_MAX_SCAN_LINE;
        regs.double_scan_on = RST_DOUBLE_SCAN;
        regs.shift_mode     = RST_SHIFT_MODE;
        regs.crtc_mode      = RST_CRTC_MODE;
        regs.frame_lines    = RST_FRAME_LINES;
        restart_frame();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_long_frame();
        test_random();

        wait_drained();
        if (expected_lines.size() != 0)
        begin
            $error("%0d results never arrived", expected_lines.size());
            error_count++;
        end
        $display("checked %0d scanlines over %0d frames, %0d line-compare restarts",
                 lines_sent, frames_seen, compare_hits);
        $display("%0d register writes across directed, long-frame and random settings",
                 reg_writes);
        if (error_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/vsag_pkg.sv
rtl/vsag_cfg_regs.sv
rtl/vsag_core.sv
rtl/vsag_out_stage.sv
rtl/vga_scanline_address_generator_top.sv
rtl/vsag_checker.sv
tb/vga_scanline_address_generator_top_tb.sv
